### rtl/ifr_pkg.sv
// ============================================================================
// ifr_pkg
// Shared types and constants for the IPv4 fragment reassembly tracker.
// ============================================================================
`default_nettype none

package ifr_pkg;

  // Reset values of the configuration registers.
  localparam logic [31:0] TIMEOUT_RST = 32'd30;
  localparam logic [15:0] MAXPAY_RST  = 16'hFFFF;

  // Default sizes of the slot and range tables.
  localparam int SLOTS_DEF  = 8;
  localparam int RANGES_DEF = 16;

  // Configuration register indexes.
  localparam logic [7:0] CFG_TIMEOUT = 8'd0;
  localparam logic [7:0] CFG_MAXPAY  = 8'd1;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_PASS     = 3'd0,
    ST_HELD     = 3'd1,
    ST_COMPLETE = 3'd2,
    ST_TOO_BIG  = 3'd3,
    ST_TOO_MANY = 3'd4
  } ifr_status_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_SLOT_RD,
    S_SLOT_CHK,
    S_DECIDE,
    S_RNG_RD,
    S_RNG_CHK,
    S_WRITEBACK,
    S_COV_RD,
    S_COV_CHK
  } ifr_state_t;

endpackage

`default_nettype wire

### rtl/ifr_ram.sv
// ============================================================================
// ifr_ram
// Generic single-write, single-read RAM with a registered read port.
// ============================================================================
`default_nettype none

module ifr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### rtl/ip_fragment_reassembly_tracker.sv
// ============================================================================
// ip_fragment_reassembly_tracker
// Tracks IPv4 fragments per datagram in a slot table and a range table,
// both held in synchronous RAMs, and reports pass, hold, completion or drop.
// ============================================================================
//
// Channel   Direction  Handshake                 Payload
// in_       input      start && !busy             src, dst, ident, flags, len, now
// out_      output     out_valid (one cycle)      status, slot, offset, total, flushed
// cfg_      input      cfg_we                     cfg_index, cfg_wdata
//
// An unfragmented header is answered in the next cycle. A fragment scans the
// slot table (one slot RAM read and one check per slot), does the range update
// and write-back and, once its end is known, makes coverage passes over the n
// stored ranges of its slot on the range RAM (up to n + 1 passes). Reset clears
// the busy flags and sets the configuration to reset values; the RAMs need no
// clear. The result beat is shown for one cycle; the next start may come with it.
// ============================================================================
`default_nettype none

module ip_fragment_reassembly_tracker import ifr_pkg::*; #(
  parameter int SLOTS  = SLOTS_DEF,
  parameter int RANGES = RANGES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [31:0] in_src_addr,
  input  wire logic [31:0] in_dst_addr,
  input  wire logic [15:0] in_ident,
  input  wire logic [15:0] in_flags_offset,
  input  wire logic [15:0] in_payload_len,
  input  wire logic [31:0] in_now,
  output logic             out_valid,
  output logic [2:0]       out_status,
  output logic [5:0]       out_slot,
  output logic [15:0]      out_write_offset,
  output logic [15:0]      out_total_len,
  output logic             out_flushed,
  input  wire logic        cfg_we,
  input  wire logic [7:0]  cfg_index,
  input  wire logic [31:0] cfg_wdata
);

  localparam int SW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW   = $clog2(RANGES + 1);
  localparam int RAD  = SLOTS * RANGES;
  localparam int RAW  = (RAD > 1) ? $clog2(RAD) : 1;
  localparam int SRW  = 32 + 32 + 16 + 32 + 17 + CW;

  // Configuration registers.
  logic [31:0] timeout_r;
  logic [15:0] maxpay_r;

  // Sequencer state and item registers.
  ifr_state_t  state_r, state_nxt;
  logic [31:0] src_r, dst_r, now_r;
  logic [15:0] id_r;
  logic        mf_r;
  logic [15:0] off_r;
  logic [16:0] endv_r;
  logic [SLOTS-1:0] busy_r;
  logic [SW-1:0] idx_r;
  logic        found_r, have_free_r;
  logic [SW-1:0] sel_r, free_r;
  logic [16:0] endk_r;
  logic [CW-1:0] cnt_r;
  logic [CW-1:0] n_r;
  logic [31:0] exp_r;
  logic [CW-1:0] j_r;
  logic [16:0] pos_r, prev_r;

  // Result registers.
  logic        out_valid_r;
  ifr_status_t out_status_r;
  logic [SW-1:0] out_slot_r;
  logic [15:0] out_off_r, out_total_r;
  logic        out_flushed_r;

  // RAM ports.
  logic          slot_we;
  logic [SW-1:0] slot_waddr, slot_raddr;
  logic [SRW-1:0] slot_wdata, slot_rdata;
  logic          rng_we;
  logic [RAW-1:0] rng_waddr, rng_raddr;
  logic [33:0]   rng_wdata, rng_rdata;

  ifr_ram #(.WIDTH(SRW), .DEPTH(SLOTS)) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .raddr (slot_raddr),
    .rdata (slot_rdata)
  );

  ifr_ram #(.WIDTH(34), .DEPTH(RAD)) u_range_ram (
    .clk   (clk),
    .we    (rng_we),
    .waddr (rng_waddr),
    .wdata (rng_wdata),
    .raddr (rng_raddr),
    .rdata (rng_rdata)
  );

  // Fields of the slot record being read.
  logic [31:0] rd_src, rd_dst, rd_exp;
  logic [15:0] rd_id;
  logic [16:0] rd_endk;
  logic [CW-1:0] rd_cnt;
  assign rd_src  = slot_rdata[SRW-1 -: 32];
  assign rd_dst  = slot_rdata[SRW-33 -: 32];
  assign rd_id   = slot_rdata[SRW-65 -: 16];
  assign rd_exp  = slot_rdata[SRW-81 -: 32];
  assign rd_endk = slot_rdata[CW+16 -: 17];
  assign rd_cnt  = slot_rdata[CW-1:0];

  function automatic logic [RAW-1:0] rng_addr(input logic [SW-1:0] s,
                                              input logic [CW-1:0] j);
    rng_addr = RAW'(int'(s) * RANGES + int'(j));
  endfunction

  // Scan checks on the slot record just read.
  logic scan_live, scan_match;
  assign scan_live  = busy_r[idx_r] && !(now_r >= rd_exp);
  assign scan_match = scan_live && (rd_id == id_r) && (rd_src == src_r) &&
                      (rd_dst == dst_r);

  // Slot choice and range count after the scan.
  logic [SW-1:0] dec_sel;
  logic [CW-1:0] dec_cnt, dec_n;
  logic [16:0]   dec_endk;
  always_comb begin
    dec_sel  = found_r ? sel_r : (have_free_r ? free_r : '0);
    dec_cnt  = found_r ? cnt_r : '0;
    dec_endk = found_r ? endk_r : '0;
    dec_n    = (dec_cnt > CW'(RANGES)) ? CW'(RANGES) : dec_cnt;
  end

  // Coverage step on the range just read.
  logic [16:0] cov_pos;
  assign cov_pos = (pos_r >= rng_rdata[33:17] && pos_r < rng_rdata[16:0]) ?
                   rng_rdata[16:0] : pos_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start && (in_flags_offset[13] || in_flags_offset[12:0] != '0)) begin
          state_nxt = S_SLOT_RD;
        end
      end
      S_SLOT_RD:  state_nxt = S_SLOT_CHK;
      S_SLOT_CHK: state_nxt = (idx_r == SW'(SLOTS - 1)) ? S_DECIDE : S_SLOT_RD;
      S_DECIDE: begin
        if (endv_r > {1'b0, maxpay_r}) begin
          state_nxt = S_IDLE;
        end else if (dec_n == '0) begin
          state_nxt = S_WRITEBACK;
        end else begin
          state_nxt = S_RNG_RD;
        end
      end
      S_RNG_RD: state_nxt = S_RNG_CHK;
      S_RNG_CHK: begin
        if (rng_rdata[16:0] != {1'b0, off_r} && n_r >= CW'(RANGES)) begin
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_WRITEBACK;
        end
      end
      S_WRITEBACK: state_nxt = endk_r[16] ? S_COV_RD : S_IDLE;
      S_COV_RD:    state_nxt = S_COV_CHK;
      S_COV_CHK: begin
        if (j_r == n_r - 1'b1) begin
          if (cov_pos >= {1'b0, endk_r[15:0]} || cov_pos == prev_r) begin
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_COV_RD;
          end
        end else begin
          state_nxt = S_COV_RD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Memory port drive.
  always_comb begin
    slot_raddr = idx_r;
    slot_we    = (state_r == S_WRITEBACK);
    slot_waddr = sel_r;
    slot_wdata = {src_r, dst_r, id_r, exp_r, endk_r, n_r};
    rng_raddr  = (state_r == S_RNG_RD) ? rng_addr(sel_r, n_r - 1'b1)
                                       : rng_addr(sel_r, j_r);
    rng_we     = 1'b0;
    rng_waddr  = rng_addr(dec_sel, '0);
    rng_wdata  = {1'b0, off_r, endv_r};
    case (state_r)
      S_DECIDE: begin
        rng_we = (endv_r <= {1'b0, maxpay_r}) && (dec_n == '0);
      end
      S_RNG_CHK: begin
        if (rng_rdata[16:0] == {1'b0, off_r}) begin
          rng_we    = 1'b1;
          rng_waddr = rng_addr(sel_r, n_r - 1'b1);
          rng_wdata = {rng_rdata[33:17], endv_r};
        end else if (n_r < CW'(RANGES)) begin
          rng_we    = 1'b1;
          rng_waddr = rng_addr(sel_r, n_r);
        end
      end
      default: rng_we = 1'b0;
    endcase
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RST;
      maxpay_r  <= MAXPAY_RST;
    end else if (cfg_we) begin
      if (cfg_index == CFG_TIMEOUT) begin
        timeout_r <= cfg_wdata;
      end else if (cfg_index == CFG_MAXPAY) begin
        maxpay_r <= cfg_wdata[15:0];
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      busy_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (start && !in_flags_offset[13] && in_flags_offset[12:0] == '0) begin
            out_valid_r <= 1'b1;
          end
        end
        S_SLOT_CHK: begin
          if (busy_r[idx_r] && !scan_live) begin
            busy_r[idx_r] <= 1'b0;
          end
        end
        S_DECIDE: begin
          if (!found_r && !have_free_r) begin
            busy_r <= '0;
          end
          busy_r[dec_sel] <= (endv_r <= {1'b0, maxpay_r});
          out_valid_r     <= (endv_r > {1'b0, maxpay_r});
        end
        S_RNG_CHK: begin
          if (rng_rdata[16:0] != {1'b0, off_r} && n_r >= CW'(RANGES)) begin
            busy_r[sel_r] <= 1'b0;
            out_valid_r   <= 1'b1;
          end
        end
        S_WRITEBACK: out_valid_r <= !endk_r[16];
        S_COV_CHK: begin
          if (j_r == n_r - 1'b1) begin
            if (cov_pos >= {1'b0, endk_r[15:0]}) begin
              busy_r[sel_r] <= 1'b0;
              out_valid_r   <= 1'b1;
            end else if (cov_pos == prev_r) begin
              out_valid_r <= 1'b1;
            end
          end
        end
        default: out_valid_r <= 1'b0;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        src_r       <= in_src_addr;
        dst_r       <= in_dst_addr;
        id_r        <= in_ident;
        now_r       <= in_now;
        mf_r        <= in_flags_offset[13];
        off_r       <= {in_flags_offset[12:0], 3'b000};
        endv_r      <= {1'b0, in_flags_offset[12:0], 3'b000} + {1'b0, in_payload_len};
        idx_r       <= '0;
        found_r     <= 1'b0;
        have_free_r <= 1'b0;
        free_r      <= '0;
        out_status_r  <= ST_PASS;
        out_slot_r    <= '0;
        out_off_r     <= '0;
        out_total_r   <= in_payload_len;
        out_flushed_r <= 1'b0;
      end
      S_SLOT_CHK: begin
        if (!scan_live && !have_free_r) begin
          have_free_r <= 1'b1;
          free_r      <= idx_r;
        end
        if (scan_match && !found_r) begin
          found_r <= 1'b1;
          sel_r   <= idx_r;
          endk_r  <= rd_endk;
          cnt_r   <= rd_cnt;
        end
        idx_r <= idx_r + 1'b1;
      end
      S_DECIDE: begin
        sel_r     <= dec_sel;
        exp_r     <= now_r + timeout_r;
        endk_r    <= mf_r ? dec_endk : {1'b1, endv_r[15:0]};
        n_r       <= (dec_n == '0) ? CW'(1) : dec_n;
        out_status_r  <= ST_TOO_BIG;
        out_slot_r    <= dec_sel;
        out_off_r     <= off_r;
        out_total_r   <= '0;
        out_flushed_r <= !found_r && !have_free_r;
      end
      S_RNG_CHK: begin
        if (rng_rdata[16:0] != {1'b0, off_r} && n_r < CW'(RANGES)) begin
          n_r <= n_r + 1'b1;
        end
        out_status_r <= ST_TOO_MANY;
      end
      S_WRITEBACK: begin
        j_r          <= '0;
        pos_r        <= '0;
        prev_r       <= '0;
        out_status_r <= ST_HELD;
      end
      S_COV_CHK: begin
        pos_r <= cov_pos;
        if (j_r == n_r - 1'b1) begin
          j_r    <= '0;
          prev_r <= cov_pos;
          if (cov_pos >= {1'b0, endk_r[15:0]}) begin
            out_status_r <= ST_COMPLETE;
            out_total_r  <= endk_r[15:0];
          end
        end else begin
          j_r <= j_r + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Port drive.
  assign busy             = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_slot         = 6'(out_slot_r);
  assign out_write_offset = out_off_r;
  assign out_total_len    = out_total_r;
  assign out_flushed      = out_flushed_r;

  // A result beat only follows an accepted item or work in progress.
  a_out_follows_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy || start))
    else $error("result beat without an item in flight");

  // A passed header never names a slot or a flush.
  a_pass_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_PASS) |-> (out_slot == '0 && !out_flushed))
    else $error("pass result carries slot or flush");

  // Reset leaves every slot free.
  a_reset_free: assert property (@(posedge clk)
    $past(!rst_n) |-> (busy_r == '0))
    else $error("slot busy after reset");

endmodule

`default_nettype wire

### sim/ip_fragment_reassembly_tracker_tb.sv
// ============================================================================
// IPv4 fragment reassembly tracker testbench
// Drives header beats through the command port and checks every result
// against a cycle-free model of the slot and range tables. Directed headers
// come first, then random datagrams cut into fragments, under several
// settings of the timeout and the payload limit.
// ============================================================================
module ip_fragment_reassembly_tracker_tb import ifr_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSLOT = SLOTS_DEF;
  localparam int NRNG  = RANGES_DEF;

  typedef struct {
    logic [31:0] src;
    logic [31:0] dst;
    logic [15:0] ident;
    logic [15:0] flags_offset;
    logic [15:0] payload_len;
    logic [31:0] now;
  } frag_hdr_t;

  typedef struct {
    ifr_status_t status;
    logic [5:0]  slot;
    logic [15:0] write_offset;
    logic [15:0] total_len;
    logic        flushed;
  } frag_verdict_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [31:0] in_src_addr;
  logic [31:0] in_dst_addr;
  logic [15:0] in_ident;
  logic [15:0] in_flags_offset;
  logic [15:0] in_payload_len;
  logic [31:0] in_now;
  logic        out_valid;
  logic [2:0]  out_status;
  logic [5:0]  out_slot;
  logic [15:0] out_write_offset;
  logic [15:0] out_total_len;
  logic        out_flushed;
  logic        cfg_we;
  logic [7:0]  cfg_index;
  logic [31:0] cfg_wdata;

  ip_fragment_reassembly_tracker dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_src_addr(in_src_addr), .in_dst_addr(in_dst_addr), .in_ident(in_ident),
    .in_flags_offset(in_flags_offset), .in_payload_len(in_payload_len),
    .in_now(in_now), .out_valid(out_valid), .out_status(out_status),
    .out_slot(out_slot), .out_write_offset(out_write_offset),
    .out_total_len(out_total_len), .out_flushed(out_flushed),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // Model of the tracker tables and registers.
  logic [31:0] mdl_timeout;
  logic [15:0] mdl_max_pay;
  logic        mdl_busy [NSLOT];
  logic [31:0] mdl_src [NSLOT];
  logic [31:0] mdl_dst [NSLOT];
  logic [15:0] mdl_ident [NSLOT];
  logic [31:0] mdl_expiry [NSLOT];
  logic        mdl_end_ok [NSLOT];
  logic [15:0] mdl_end [NSLOT];
  int          mdl_nrng [NSLOT];
  logic [16:0] mdl_rs [NSLOT][NRNG];
  logic [16:0] mdl_re [NSLOT][NRNG];

  frag_hdr_t     hdr_pending [$];
  frag_verdict_t verdict_q [$];
  frag_hdr_t     hdr_on_port;
  int            send_idle_pct;
  int            err_count;
  logic [31:0]   cur_now;

  // Clock.
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Works out the verdict for one header and updates the model tables.
  function automatic frag_verdict_t track_fragment(frag_hdr_t h);
    frag_verdict_t v;
    logic          mf;
    logic [16:0]   off;
    logic [16:0]   fin;
    logic [16:0]   pos;
    logic [16:0]   prev;
    logic          found;
    logic          have_free;
    int            free_idx;
    int            s;
    int            n;
    v.status = ST_HELD;
    v.slot = '0;
    v.write_offset = '0;
    v.total_len = '0;
    v.flushed = 1'b0;
    mf = h.flags_offset[13];
    off = {1'b0, h.flags_offset[12:0], 3'b000};
    if (!mf && off == 0) begin
      v.status = ST_PASS;
      v.total_len = h.payload_len;
      return v;
    end
    // Age out, then look up or allocate a slot.
    for (int i = 0; i < NSLOT; i++)
      if (mdl_busy[i] && h.now >= mdl_expiry[i]) mdl_busy[i] = 1'b0;
    found = 1'b0;
    have_free = 1'b0;
    free_idx = 0;
    s = 0;
    for (int i = 0; i < NSLOT; i++) begin
      if (!mdl_busy[i]) begin
        if (!have_free) begin
          have_free = 1'b1;
          free_idx = i;
        end
      end else if (!found && mdl_ident[i] == h.ident && mdl_src[i] == h.src &&
                   mdl_dst[i] == h.dst) begin
        found = 1'b1;
        s = i;
      end
    end
    if (!found) begin
      if (have_free) begin
        s = free_idx;
      end else begin
        for (int i = 0; i < NSLOT; i++) mdl_busy[i] = 1'b0;
        s = 0;
        v.flushed = 1'b1;
      end
      mdl_busy[s] = 1'b1;
      mdl_ident[s] = h.ident;
      mdl_src[s] = h.src;
      mdl_dst[s] = h.dst;
      mdl_nrng[s] = 0;
      mdl_end_ok[s] = 1'b0;
    end
    mdl_expiry[s] = h.now + mdl_timeout;
    v.slot = 6'(s);
    v.write_offset = off[15:0];
    fin = off + {1'b0, h.payload_len};
    if (fin > {1'b0, mdl_max_pay}) begin
      mdl_busy[s] = 1'b0;
      v.status = ST_TOO_BIG;
      return v;
    end
    if (!mf) begin
      mdl_end_ok[s] = 1'b1;
      mdl_end[s] = fin[15:0];
    end
    // Record the range, merging with the previous one when contiguous.
    n = mdl_nrng[s];
    if (n == 0) begin
      mdl_rs[s][0] = off;
      mdl_re[s][0] = fin;
      n = 1;
    end else if (mdl_re[s][n-1] == off) begin
      mdl_re[s][n-1] = fin;
    end else if (n >= NRNG) begin
      mdl_busy[s] = 1'b0;
      v.status = ST_TOO_MANY;
      return v;
    end else begin
      mdl_rs[s][n] = off;
      mdl_re[s][n] = fin;
      n++;
    end
    mdl_nrng[s] = n;
    // Repeated coverage passes until the front stops moving.
    if (mdl_end_ok[s]) begin
      pos = '0;
      forever begin
        prev = pos;
        for (int i = 0; i < n; i++)
          if (pos >= mdl_rs[s][i] && pos < mdl_re[s][i]) pos = mdl_re[s][i];
        if (pos >= {1'b0, mdl_end[s]}) begin
          mdl_busy[s] = 1'b0;
          v.status = ST_COMPLETE;
          v.total_len = mdl_end[s];
          return v;
        end
        if (pos == prev) break;
      end
    end
    return v;
  endfunction

  // Driver: records each accepted beat, then presents the next one or idles.
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) verdict_q.push_back(track_fragment(hdr_on_port));
      if (!start || !busy) begin
        if (hdr_pending.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          hdr_on_port = hdr_pending.pop_front();
          start <= 1'b1;
          in_src_addr <= hdr_on_port.src;
          in_dst_addr <= hdr_on_port.dst;
          in_ident <= hdr_on_port.ident;
          in_flags_offset <= hdr_on_port.flags_offset;
          in_payload_len <= hdr_on_port.payload_len;
          in_now <= hdr_on_port.now;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, name, want, got);
      err_count++;
    end
  endtask

  // Monitor: each result beat against the oldest verdict.
  always @(posedge clk) begin
    frag_verdict_t w;
    if (rst_n && out_valid) begin
      if (verdict_q.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, actual status %0d",
                 $realtime, out_status);
        err_count++;
      end else begin
        w = verdict_q.pop_front();
        check_field("status", 32'(w.status), 32'(out_status));
        check_field("slot", 32'(w.slot), 32'(out_slot));
        check_field("write_offset", 32'(w.write_offset), 32'(out_write_offset));
        check_field("total_len", 32'(w.total_len), 32'(out_total_len));
        check_field("flushed", 32'(w.flushed), 32'(out_flushed));
      end
    end
  end

  task automatic add_hdr(logic [31:0] src, logic [31:0] dst, logic [15:0] id,
                         logic [12:0] off_units, logic mf, logic [15:0] len);
    frag_hdr_t h;
    h.src = src;
    h.dst = dst;
    h.ident = id;
    h.flags_offset = {1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), mf, off_units};
    h.payload_len = len;
    if ($urandom_range(0, 49) == 0) cur_now += $urandom_range(20, 300);
    else cur_now += $urandom_range(0, 3);
    h.now = cur_now;
    hdr_pending.push_back(h);
  endtask

  // Random datagrams cut into fragments, mixed with broken ones and noise.
  task automatic add_random(int count);
    logic [31:0] key_src [12];
    logic [31:0] key_dst [12];
    logic [15:0] key_id [12];
    frag_hdr_t   frags [$];
    frag_hdr_t   tmp;
    int          k;
    int          nfr;
    int          units;
    int          pos;
    int          j;
    int          added;
    for (int i = 0; i < 12; i++) begin
      key_src[i] = $urandom;
      key_dst[i] = $urandom;
      key_id[i] = 16'($urandom);
    end
    added = 0;
    while (added < count) begin
      k = $urandom_range(0, 99);
      if (k < 8) begin
        // Noise: every field random.
        tmp.src = $urandom;
        tmp.dst = $urandom;
        tmp.ident = 16'($urandom);
        tmp.flags_offset = 16'($urandom);
        tmp.payload_len = 16'($urandom);
        tmp.now = $urandom;
        hdr_pending.push_back(tmp);
        added++;
      end else begin
        j = $urandom_range(0, 11);
        if ($urandom_range(0, 9) == 0) key_id[j] = 16'($urandom);
        nfr = $urandom_range(1, 6);
        pos = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 8000) : 0;
        frags.delete();
        for (int f = 0; f < nfr; f++) begin
          units = ($urandom_range(0, 29) == 0) ? $urandom_range(1, 2000)
                                               : $urandom_range(1, 8);
          tmp.src = key_src[j];
          tmp.dst = key_dst[j];
          tmp.ident = key_id[j];
          tmp.flags_offset = {3'b001, 13'(pos)};
          if (f == nfr - 1) begin
            tmp.flags_offset[13] = 1'b0;
            tmp.payload_len = 16'($urandom_range(0, units * 8));
          end else begin
            tmp.payload_len = 16'(units * 8);
          end
          frags.push_back(tmp);
          pos += units;
        end
        // Reorder, repeat or lose fragments now and then.
        if ($urandom_range(0, 2) == 0)
          for (int f = frags.size() - 1; f > 0; f--) begin
            k = $urandom_range(0, f);
            tmp = frags[f];
            frags[f] = frags[k];
            frags[k] = tmp;
          end
        if ($urandom_range(0, 9) == 0) frags.push_back(frags[$urandom_range(0, nfr - 1)]);
        if ($urandom_range(0, 9) == 0) frags.delete($urandom_range(0, frags.size() - 1));
        foreach (frags[f]) begin
          add_hdr(frags[f].src, frags[f].dst, frags[f].ident,
                  frags[f].flags_offset[12:0], frags[f].flags_offset[13],
                  frags[f].payload_len);
          added++;
        end
      end
    end
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (hdr_pending.size() != 0 || start || verdict_q.size() != 0);
    repeat (20) @(posedge clk);
  endtask

  // One register write; the strobe drops again before the next write.
  task automatic write_reg(logic [7:0] idx, logic [31:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    if (idx == CFG_TIMEOUT) mdl_timeout = value;
    else if (idx == CFG_MAXPAY) mdl_max_pay = value[15:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Stimulus and phases.
  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_src_addr = '0;
    in_dst_addr = '0;
    in_ident = '0;
    in_flags_offset = '0;
    in_payload_len = '0;
    in_now = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    err_count = 0;
    send_idle_pct = 12;
    cur_now = 32'd1000;
    mdl_timeout = TIMEOUT_RST;
    mdl_max_pay = MAXPAY_RST;
    for (int i = 0; i < NSLOT; i++) mdl_busy[i] = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Unfragmented headers at the field extremes, reserved and DF bits random.
    add_hdr('1, '1, '1, 13'd0, 1'b0, 16'hFFFF);
    add_hdr('0, '0, '0, 13'd0, 1'b0, 16'h0000);
    // Largest offset: fits exactly, then one byte over.
    add_hdr(32'h0A000001, 32'h0A000002, 16'h0001, 13'h1FFF, 1'b1, 16'd7);
    add_hdr(32'h0A000001, 32'h0A000002, 16'h0002, 13'h1FFF, 1'b1, 16'd8);
    // Zero-length range, merge, completion, then a repeated last fragment.
    add_hdr(32'h0A000003, 32'h0A000004, 16'h0003, 13'd0, 1'b1, 16'd0);
    add_hdr(32'h0A000003, 32'h0A000004, 16'h0003, 13'd0, 1'b1, 16'd16);
    add_hdr(32'h0A000003, 32'h0A000004, 16'h0003, 13'd2, 1'b0, 16'd8);
    add_hdr(32'h0A000003, 32'h0A000004, 16'h0003, 13'd2, 1'b0, 16'd8);
    // A later last fragment moves the end down and completes the datagram.
    add_hdr(32'h0A000005, 32'h0A000006, 16'h0004, 13'd0, 1'b1, 16'd8);
    add_hdr(32'h0A000005, 32'h0A000006, 16'h0004, 13'd2, 1'b0, 16'd8);
    add_hdr(32'h0A000005, 32'h0A000006, 16'h0004, 13'd1, 1'b0, 16'd0);
    // Seventeen disjoint ranges overflow the range table.
    for (int i = 0; i < 17; i++)
      add_hdr(32'h0A000007, 32'h0A000008, 16'h0005, 13'(2 * i), 1'b1, 16'd8);
    add_random(400);
    wait_drained();

    send_idle_pct = 66;
    write_reg(CFG_TIMEOUT, 32'hFFFFFFFF);
    write_reg(CFG_MAXPAY, 32'hFFFF05DC);
    write_reg(8'd2, 32'h00000003);
    add_random(350);
    wait_drained();

    write_reg(CFG_TIMEOUT, 32'd1);
    write_reg(CFG_MAXPAY, 32'd0);
    add_random(100);
    wait_drained();

    send_idle_pct = 0;
    write_reg(CFG_TIMEOUT, 32'd100000);
    write_reg(CFG_MAXPAY, 32'd65535);
    add_random(370);
    wait_drained();

    if (err_count == 0) begin
      $display("ip_fragment_reassembly_tracker_tb passed");
    end else begin
      $display("ip_fragment_reassembly_tracker_tb failed");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #50ms;
    $display("ip_fragment_reassembly_tracker_tb failed");
    $finish;
  end

endmodule

### sim.f
rtl/ifr_pkg.sv
rtl/ifr_ram.sv
rtl/ip_fragment_reassembly_tracker.sv
sim/ip_fragment_reassembly_tracker_tb.sv
